// ===== design/rbjg_pkg.sv =====
package rbjg_pkg;

    localparam int DELAY_W = 32;
    localparam int PCT_W   = 7;
    localparam int SEED_W  = 64;
    localparam int MUL_W   = 2 * DELAY_W;
    localparam int DSR_W   = DELAY_W + 1;
    localparam int STEP_W  = 6;
    localparam int CFG_AW  = 2;

    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 7;
    localparam int SHIFT_C = 17;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // divide by a hundred through reciprocal multiplication
    localparam logic [DELAY_W-1:0] RECIP_100 = 32'h51EB_851F;
    localparam int RECIP_SH = 37;

    // fraction times percent stays at or below 9900
    localparam int LO_W        = 2 * PCT_W;
    localparam int LO_RECIP_W  = 13;
    localparam int LOP_W       = LO_W + LO_RECIP_W;
    localparam logic [LO_RECIP_W-1:0] LO_RECIP_100 = 13'd5243;
    localparam int LO_RECIP_SH = 19;

    // two quotient bits per divider step
    localparam logic [STEP_W-1:0] MDIV_STEPS = 6'd32;

    localparam logic [CFG_AW-1:0] REG_INITIAL = 2'd0;
    localparam logic [CFG_AW-1:0] REG_MAX     = 2'd1;
    localparam logic [CFG_AW-1:0] REG_PCT     = 2'd2;
    localparam logic [CFG_AW-1:0] REG_SEED    = 2'd3;

    typedef struct packed {
        logic load;
        logic dbl;
        logic recip;
        logic split;
        logic scale;
        logic range_load;
        logic mdiv_start;
        logic fin;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic dbl_done;
        logic div_busy;
        logic range_zero;
        logic out_free;
    } stat_t;

endpackage

// ===== design/rbjg_div.sv =====
module rbjg_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [rbjg_pkg::SEED_W-1:0]     dividend,
    input  logic [rbjg_pkg::DSR_W-1:0]      divisor,
    input  logic [rbjg_pkg::STEP_W-1:0]     steps,
    output logic                            busy,
    output logic [rbjg_pkg::DSR_W-1:0]      rem
);

    logic [rbjg_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic [rbjg_pkg::SEED_W-1:0] dvd_reg, dvd_next;
    logic [rbjg_pkg::DSR_W-1:0]  rem_reg, rem_next;
    logic [rbjg_pkg::DSR_W-1:0]  dsr_reg, dsr_next;

    logic [rbjg_pkg::DSR_W:0]    r0, r1, r2, r3;
    logic                        ge0, ge1;

    always_comb
    begin
        r0  = {rem_reg, dvd_reg[rbjg_pkg::SEED_W-1]};
        ge0 = (r0 >= {1'b0, dsr_reg});
        r1  = ge0 ? (r0 - {1'b0, dsr_reg}) : r0;
        r2  = {r1[rbjg_pkg::DSR_W-1:0], dvd_reg[rbjg_pkg::SEED_W-2]};
        ge1 = (r2 >= {1'b0, dsr_reg});
        r3  = ge1 ? (r2 - {1'b0, dsr_reg}) : r2;

        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (start)
        begin
            cnt_next = steps;
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = {dvd_reg[rbjg_pkg::SEED_W-3:0], ge0, ge1};
            rem_next = r3[rbjg_pkg::DSR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy = (cnt_reg != '0);
    assign rem  = rem_reg;

endmodule

// ===== design/rbjg_dp.sv =====
module rbjg_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  rbjg_pkg::cmd_t                  cmd,
    output rbjg_pkg::stat_t                 stat,
    input  logic                            cfg_we,
    input  logic [rbjg_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [rbjg_pkg::SEED_W-1:0]     cfg_data,
    input  logic [rbjg_pkg::DELAY_W-1:0]    attempt_number,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rbjg_pkg::DELAY_W-1:0]    backoff_ms,
    output logic                            jitter_applied
);

    logic [rbjg_pkg::DELAY_W-1:0] init_reg, init_next;
    logic [rbjg_pkg::DELAY_W-1:0] max_reg, max_next;
    logic [rbjg_pkg::PCT_W-1:0]   pct_reg, pct_next;
    logic [rbjg_pkg::SEED_W-1:0]  prng_reg, prng_next;
    logic [rbjg_pkg::DELAY_W-1:0] cnt_reg, cnt_next;
    logic [rbjg_pkg::DELAY_W-1:0] delay_reg, delay_next;
    logic [rbjg_pkg::DELAY_W-1:0] hund_reg, hund_next;
    logic [rbjg_pkg::PCT_W-1:0]   frac_reg, frac_next;
    logic [rbjg_pkg::DELAY_W-1:0] hi_reg, hi_next;
    logic [rbjg_pkg::LO_W-1:0]    lo_reg, lo_next;
    logic [rbjg_pkg::DELAY_W-1:0] range_reg, range_next;
    logic [rbjg_pkg::DELAY_W-1:0] res_reg, res_next;
    logic                         jit_reg, jit_next;
    logic                         ovalid_reg, ovalid_next;
    logic [rbjg_pkg::DELAY_W-1:0] odata_reg, odata_next;
    logic                         ouser_reg, ouser_next;

    logic [rbjg_pkg::SEED_W-1:0]  x0, x1, x2;
    logic [rbjg_pkg::PCT_W-1:0]   pct_sat;
    logic [rbjg_pkg::MUL_W-1:0]   recip_prod;
    logic [rbjg_pkg::DELAY_W-1:0] hund_x100;
    logic [rbjg_pkg::LOP_W-1:0]   lo_prod;
    logic                         div_busy;
    logic [rbjg_pkg::DSR_W-1:0]   div_rem;
    logic [rbjg_pkg::DSR_W:0]     up_sum;
    logic [rbjg_pkg::DSR_W:0]     max_ext;

    rbjg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mdiv_start),
        .dividend (x2),
        .divisor  ({range_reg, 1'b1}),
        .steps    (rbjg_pkg::MDIV_STEPS),
        .busy     (div_busy),
        .rem      (div_rem)
    );

    // xorshift advance
    always_comb
    begin
        x0 = prng_reg ^ (prng_reg << rbjg_pkg::SHIFT_A);
        x1 = x0 ^ (x0 >> rbjg_pkg::SHIFT_B);
        x2 = x1 ^ (x1 << rbjg_pkg::SHIFT_C);
    end

    assign pct_sat = (pct_reg > rbjg_pkg::PCT_FULL) ? rbjg_pkg::PCT_FULL : pct_reg;

    // range = (delay / 100) * pct + (delay % 100) * pct / 100
    assign recip_prod = rbjg_pkg::MUL_W'(delay_reg) * rbjg_pkg::MUL_W'(rbjg_pkg::RECIP_100);
    assign hund_x100  = hund_reg * rbjg_pkg::DELAY_W'(rbjg_pkg::PCT_FULL);
    assign lo_prod    = rbjg_pkg::LOP_W'(lo_reg) * rbjg_pkg::LOP_W'(rbjg_pkg::LO_RECIP_100);

    assign max_ext = {2'b00, max_reg};
    assign up_sum  = {2'b00, delay_reg} + {1'b0, div_rem} - {2'b00, range_reg};

    always_comb
    begin
        init_next   = init_reg;
        max_next    = max_reg;
        pct_next    = pct_reg;
        prng_next   = prng_reg;
        cnt_next    = cnt_reg;
        delay_next  = delay_reg;
        hund_next   = hund_reg;
        frac_next   = frac_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        range_next  = range_reg;
        res_next    = res_reg;
        jit_next    = jit_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        ouser_next  = ouser_reg;

        if (cfg_we)
        begin
            unique case (cfg_addr)
                rbjg_pkg::REG_INITIAL: init_next = cfg_data[rbjg_pkg::DELAY_W-1:0];
                rbjg_pkg::REG_MAX:     max_next  = cfg_data[rbjg_pkg::DELAY_W-1:0];
                rbjg_pkg::REG_PCT:     pct_next  = cfg_data[rbjg_pkg::PCT_W-1:0];
                rbjg_pkg::REG_SEED:
                begin
                    prng_next = (cfg_data == '0) ? rbjg_pkg::SEED_W'(1) : cfg_data;
                end
                default: ;
            endcase
        end

        if (cmd.load)
        begin
            delay_next = (init_reg > max_reg) ? max_reg : init_reg;
            cnt_next   = attempt_number;
        end

        if (cmd.dbl)
        begin
            delay_next = (delay_reg > (max_reg >> 1)) ? max_reg : (delay_reg << 1);
            cnt_next   = cnt_reg - 1'b1;
        end

        if (cmd.recip)
        begin
            hund_next = rbjg_pkg::DELAY_W'(recip_prod >> rbjg_pkg::RECIP_SH);
        end

        if (cmd.split)
        begin
            frac_next = rbjg_pkg::PCT_W'(delay_reg - hund_x100);
        end

        if (cmd.scale)
        begin
            hi_next = hund_reg * rbjg_pkg::DELAY_W'(pct_sat);
            lo_next = rbjg_pkg::LO_W'(frac_reg) * rbjg_pkg::LO_W'(pct_sat);
        end

        if (cmd.range_load)
        begin
            range_next = hi_reg + rbjg_pkg::DELAY_W'(lo_prod >> rbjg_pkg::LO_RECIP_SH);
        end

        if (cmd.mdiv_start)
        begin
            prng_next = x2;
        end

        if (cmd.fin)
        begin
            jit_next = (range_reg != '0);
            if (range_reg == '0)
            begin
                res_next = delay_reg;
            end
            else if (div_rem < {1'b0, range_reg})
            begin
                res_next = delay_reg - div_rem[rbjg_pkg::DELAY_W-1:0];
            end
            else if (up_sum > max_ext)
            begin
                res_next = max_reg;
            end
            else
            begin
                res_next = up_sum[rbjg_pkg::DELAY_W-1:0];
            end
        end

        if (cmd.out_load)
        begin
            ovalid_next = 1'b1;
            odata_next  = res_reg;
            ouser_next  = jit_reg;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg   <= 32'd100;
            max_reg    <= 32'd30000;
            pct_reg    <= 7'd20;
            prng_reg   <= 64'd1;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            init_reg   <= init_next;
            max_reg    <= max_next;
            pct_reg    <= pct_next;
            prng_reg   <= prng_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        delay_reg <= delay_next;
        hund_reg  <= hund_next;
        frac_reg  <= frac_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        range_reg <= range_next;
        res_reg   <= res_next;
        jit_reg   <= jit_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
    end

    assign stat.dbl_done   = (cnt_reg == '0) || (delay_reg >= max_reg) || (delay_reg == '0);
    assign stat.div_busy   = div_busy;
    assign stat.range_zero = (range_reg == '0);
    assign stat.out_free   = !ovalid_reg || out_ready;

    assign out_valid      = ovalid_reg;
    assign backoff_ms     = odata_reg;
    assign jitter_applied = ouser_reg;

endmodule

// ===== design/rbjg_ctrl.sv =====
module rbjg_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rbjg_pkg::stat_t stat,
    output rbjg_pkg::cmd_t  cmd
);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_DOUBLE,
        S_RECIP,
        S_SPLIT,
        S_SCALE,
        S_RANGE,
        S_MSTART,
        S_MDIV,
        S_FIN,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DOUBLE;
                end
            end
            S_DOUBLE:
            begin
                if (stat.dbl_done)
                begin
                    state_next = S_RECIP;
                end
                else
                begin
                    cmd.dbl = 1'b1;
                end
            end
            S_RECIP:
            begin
                cmd.recip  = 1'b1;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_RANGE;
            end
            S_RANGE:
            begin
                cmd.range_load = 1'b1;
                state_next     = S_MSTART;
            end
            S_MSTART:
            begin
                if (stat.range_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.mdiv_start = 1'b1;
                    state_next     = S_MDIV;
                end
            end
            S_MDIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/retry_backoff_jitter_generator.sv =====
// Retry backoff generator: each input word carries a failed-attempt count and
// yields one output word with the retry delay in ms (tdata) and a jitter flag
// (tuser). The base delay starts at initial_delay, doubles per attempt and
// saturates at max_delay; jitter of up to jitter_pct percent of the base is
// drawn from a 64-bit xorshift generator and the result is clamped to
// max_delay. One word is processed at a time: once it is taken, its base is
// doubled once per attempt (at most 32 doublings), then the jitter range is
// formed through a reciprocal multiply by a hundred, a split, a scale and a sum;
// a jittered word then passes through the radix-4 divider that reduces the
// random draw modulo the span before the result is formed. The
// next input word is taken the cycle after a result enters the output
// register, where it waits until accepted; a later result stalls the block
// while that register is still full. Configure only while idle; writing
// random_seed reloads the generator.
module retry_backoff_jitter_generator
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rbjg_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [rbjg_pkg::SEED_W-1:0]     cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rbjg_pkg::DELAY_W-1:0]    s_axis_tdata,   // attempt_number
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rbjg_pkg::DELAY_W-1:0]    m_axis_tdata,   // backoff_ms
    output logic                            m_axis_tuser    // jitter_applied
);

    rbjg_pkg::cmd_t  cmd;
    rbjg_pkg::stat_t stat;

    rbjg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rbjg_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .attempt_number (s_axis_tdata),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .backoff_ms     (m_axis_tdata),
        .jitter_applied (m_axis_tuser)
    );

endmodule

// ===== dv/retry_backoff_jitter_generator_test.sv =====
module retry_backoff_jitter_generator_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rbjg_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int PHASE_WORDS   = 150;
    localparam int RANDOM_PHASES = 12;
    localparam int PRESS_AT      = 120;
    localparam int PRESS_CYCLES  = 800;
    localparam int STUCK_LIMIT   = 5000;
    localparam int TAIL_CYCLES   = 120;

    typedef struct packed {
        logic [DELAY_W-1:0] backoff_ms;
        logic               jitter_applied;
    } backoff_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_AW-1:0]   cfg_addr = '0;
    logic [SEED_W-1:0]   cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DELAY_W-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [DELAY_W-1:0]  m_axis_tdata;
    logic                m_axis_tuser;

    // predictor copy of the registers and the generator
    logic [DELAY_W-1:0]  cur_initial;
    logic [DELAY_W-1:0]  cur_max;
    logic [PCT_W-1:0]    cur_pct;
    logic [SEED_W-1:0]   prng;

    logic [DELAY_W-1:0]  pending_attempts[$];
    backoff_t            delay_expect[$];

    bit                  burst;
    bit                  pressed;
    int                  send_gap;
    int                  hold_left;
    int                  stuck_cycles;
    int                  sent_words;
    int                  got_words;
    int                  jittered_words;
    int                  mismatches;
    int                  settings_used;

    retry_backoff_jitter_generator i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    function automatic backoff_t backoff_delay(input logic [DELAY_W-1:0] attempt);
        logic [63:0] base;
        logic [63:0] ceil;
        logic [63:0] pct;
        logic [63:0] spread;
        logic [63:0] span;
        logic [63:0] pick;
        logic [63:0] outv;
        longint      n;
        backoff_t    r;
        ceil = 64'(cur_max);
        base = 64'(cur_initial);
        pct = (cur_pct > PCT_FULL) ? 64'(PCT_FULL) : 64'(cur_pct);
        if (base > ceil)
            base = ceil;
        n = 0;
        while (n < longint'(attempt) && base < ceil && base != 0)
        begin
            base = (base > ceil / 2) ? ceil : base * 2;
            n++;
        end
        r.backoff_ms = base[DELAY_W-1:0];
        r.jitter_applied = 1'b0;
        if (pct == 0 || base == 0)
            return r;
        spread = (base / 64'(PCT_FULL)) * pct + (base % 64'(PCT_FULL)) * pct / 64'(PCT_FULL);
        if (spread == 0)
            return r;
        span = spread * 2 + 1;
        prng ^= prng << SHIFT_A;
        prng ^= prng >> SHIFT_B;
        prng ^= prng << SHIFT_C;
        pick = prng % span;
        outv = (pick < spread) ? base - pick : base + (pick - spread);
        if (outv > ceil)
            outv = ceil;
        r.backoff_ms = outv[DELAY_W-1:0];
        r.jitter_applied = 1'b1;
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [DELAY_W-1:0] random_attempt();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 40);
        else if (r < 90)
            return $urandom_range(0, 12);
        else
            return $urandom;
    endfunction

    function automatic logic [DELAY_W-1:0] random_delay(input bit ceiling);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return ceiling ? $urandom_range(1, 100000) : $urandom_range(1, 1000);
        else if (r < 65)
            return $urandom_range(1, 3);
        else if (r < 88)
            return $urandom;
        else if (r < 96)
            return '1;
        else
            return '0;
    endfunction

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [SEED_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            REG_INITIAL: cur_initial = val[DELAY_W-1:0];
            REG_MAX:     cur_max = val[DELAY_W-1:0];
            REG_PCT:     cur_pct = val[PCT_W-1:0];
            REG_SEED:    prng = (val == 0) ? 64'd1 : val;
            default:     ;
        endcase
    endtask

    // upper data bits carry junk that the block must drop
    task automatic load_settings(input logic [DELAY_W-1:0] init_v, input logic [DELAY_W-1:0] max_v,
                                 input logic [PCT_W-1:0] pct_v, input logic [SEED_W-1:0] seed_v,
                                 input bit with_seed);
        write_reg(REG_INITIAL, {32'($urandom), init_v});
        write_reg(REG_MAX, {32'($urandom), max_v});
        write_reg(REG_PCT, {32'($urandom), 25'($urandom), pct_v});
        if (with_seed)
            write_reg(REG_SEED, seed_v);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_attempts.size() != 0 || s_axis_tvalid || delay_expect.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                delay_expect.push_back(backoff_delay(s_axis_tdata));
                sent_words++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_attempts.size() != 0)
                begin
                    s_axis_tdata <= pending_attempts.pop_front();
                    s_axis_tvalid <= 1'b1;
                    send_gap <= pick_gap();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        backoff_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_words++;
                if (delay_expect.size() == 0)
                begin
                    $error("unexpected word: backoff_ms %0d jitter_applied %0d",
                           m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end
                else
                begin
                    want = delay_expect.pop_front();
                    if (m_axis_tdata !== want.backoff_ms)
                    begin
                        $error("backoff_ms: expected %0d, actual %0d",
                               want.backoff_ms, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tuser !== want.jitter_applied)
                    begin
                        $error("jitter_applied: expected %0d, actual %0d",
                               want.jitter_applied, m_axis_tuser);
                        mismatches++;
                    end
                    if (want.jitter_applied)
                        jittered_words++;
                end
            end
            // one long hold-off so the block backs up into its input
            if (got_words == PRESS_AT && !pressed)
            begin
                pressed = 1'b1;
                hold_left <= PRESS_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!burst && $urandom_range(0, 9) == 0)
            begin
                hold_left <= pick_gap();
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            stuck_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else if (stuck_cycles == STUCK_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", STUCK_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        int p;
        int k;
        cur_initial = 32'd100;
        cur_max = 32'd30000;
        cur_pct = 7'd20;
        prng = 64'd1;
        settings_used = 1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: growth, saturation, huge attempt count
        pending_attempts = '{32'd0, 32'd1, 32'd2, 32'd8, 32'd9, 32'hFFFF_FFFF};
        wait_idle();

        // full-scale delays, percent above hundred, zero seed
        load_settings('1, '1, 7'd127, 64'd0, 1'b1);
        pending_attempts = '{32'd0, 32'hFFFF_FFFF, 32'd5};
        wait_idle();

        // initial above maximum, all-ones seed
        load_settings(32'd50000, 32'd1000, 7'd100, '1, 1'b1);
        pending_attempts = '{32'd0, 32'd3};
        wait_idle();

        // zero initial delay
        load_settings(32'd0, 32'd30000, 7'd50, 64'h0123_4567_89AB_CDEF, 1'b1);
        pending_attempts = '{32'd0, 32'd7};
        wait_idle();

        // zero maximum
        load_settings(32'd100, 32'd0, 7'd50, 64'd0, 1'b0);
        pending_attempts = '{32'd0, 32'd4};
        wait_idle();

        // jitter off
        load_settings(32'd1, 32'd8, 7'd0, 64'd0, 1'b0);
        pending_attempts = '{32'd0, 32'd2, 32'd40};
        wait_idle();

        // range rounds to zero until the base reaches a hundred
        load_settings(32'd1, '1, 7'd1, 64'd0, 1'b0);
        pending_attempts = '{32'd0, 32'd6, 32'd7, 32'd31};
        wait_idle();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            load_settings(random_delay(1'b0), random_delay(1'b1), 7'($urandom_range(0, 127)),
                          {32'($urandom), 32'($urandom)}, 1'($urandom));
            burst = (p % 4 == 3);
            for (k = 0; k < PHASE_WORDS; k++)
                pending_attempts.push_back(random_attempt());
            wait_idle();
            burst = 1'b0;
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("checked %0d of %0d words over %0d register settings, %0d with jitter drawn",
                 got_words, sent_words, settings_used, jittered_words);
        if (mismatches == 0 && delay_expect.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
